[hw/rtl/priority_tagged_fifo_queue_unit_defines.svh]
// Assertion macros for the priority tagged FIFO queue unit
`ifndef PRIORITY_TAGGED_FIFO_QUEUE_UNIT_DEFINES_SVH
`define PRIORITY_TAGGED_FIFO_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PTFQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptfq assertion failed");

// next-cycle implication, checked outside reset
`define PTFQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ptfq assertion failed");

`endif

[hw/rtl/ptfq_pkg.sv]
// Shared types and constants for the priority tagged FIFO queue
package ptfq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VALUE_W   = 32;
  localparam int PRIO_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic                      cmd;
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]         priority_req;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] removed_value;
    logic [STATUS_W-1:0]       status;
    logic [OCC_W-1:0]          occupancy;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic                latch;
    logic                wr_insert;
    logic                wr_shift;
    logic                rd_en;
    logic                rd_next;
    logic                idx_clr;
    logic                idx_inc;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                res_set;
    logic                res_take;
    logic [STATUS_W-1:0] res_code;
    logic                load_out;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic last;
    logic prio_hit;
    logic out_free;
  } stat_t;

endpackage

[hw/rtl/ptfq_dp.sv]
// Datapath: entry memories, count, scan index, result and output register
module ptfq_dp #(
  parameter int DEPTH = ptfq_pkg::DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  ptfq_pkg::req_t  req_word,
  input  ptfq_pkg::ctrl_t ctrl,
  input  logic            rsp_ready,
  output ptfq_pkg::stat_t stat,
  output logic            rsp_valid,
  output ptfq_pkg::rsp_t  rsp_word
);
  import ptfq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [VALUE_W-1:0] mem_value [DEPTH];
  logic [PRIO_W-1:0]         mem_prio  [DEPTH];

  logic                      cmd_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [PRIO_W-1:0]         prio_q;

  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_plus;

  logic signed [VALUE_W-1:0] rd_value;
  logic [PRIO_W-1:0]         rd_prio;
  logic [AW-1:0]             rd_addr;

  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic signed [VALUE_W-1:0] wr_value;
  logic [PRIO_W-1:0]         wr_prio;

  logic signed [VALUE_W-1:0] res_value;
  logic [STATUS_W-1:0]       res_status;

  assign idx_plus = idx + CW'(1);
  assign rd_addr  = ctrl.rd_next ? idx_plus[AW-1:0] : idx[AW-1:0];

  // insert writes at the tail, shift moves entry idx+1 down into idx
  always_comb begin
    wr_en    = ctrl.wr_insert | ctrl.wr_shift;
    wr_addr  = ctrl.wr_insert ? count[AW-1:0] : idx[AW-1:0];
    wr_value = ctrl.wr_insert ? value_q : rd_value;
    wr_prio  = ctrl.wr_insert ? prio_q : rd_prio;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_value[wr_addr] <= wr_value;
      mem_prio[wr_addr]  <= wr_prio;
    end
    if (ctrl.rd_en) begin
      rd_value <= mem_value[rd_addr];
      rd_prio  <= mem_prio[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      cmd_q   <= req_word.cmd;
      value_q <= req_word.value;
      prio_q  <= req_word.priority_req;
    end
    if (ctrl.res_set) begin
      res_status <= ctrl.res_code;
      res_value  <= ctrl.res_take ? rd_value : '0;
    end
    if (ctrl.load_out) begin
      rsp_word.removed_value <= res_value;
      rsp_word.status        <= res_status;
      rsp_word.occupancy     <= OCC_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctrl.cnt_inc) begin
        count <= count + CW'(1);
      end else if (ctrl.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (ctrl.idx_clr) begin
        idx <= '0;
      end else if (ctrl.idx_inc) begin
        idx <= idx_plus;
      end
      if (ctrl.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.is_remove = (cmd_q == CMD_REMOVE);
    stat.full      = (count == CW'(DEPTH));
    stat.empty     = (count == '0);
    stat.last      = (idx_plus >= count);
    stat.prio_hit  = (rd_prio == prio_q);
    stat.out_free  = ~rsp_valid | rsp_ready;
  end

endmodule

[hw/rtl/ptfq_ctrl.sv]
// Controller: sequences insert, scan and compaction for one command word
module ptfq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  ptfq_pkg::stat_t stat,
  output ptfq_pkg::ctrl_t ctrl
);
  import ptfq_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECIDE   = 3'd1;
  localparam logic [2:0] S_SCAN_RD  = 3'd2;
  localparam logic [2:0] S_SCAN_CMP = 3'd3;
  localparam logic [2:0] S_SH_CHK   = 3'd4;
  localparam logic [2:0] S_SH_RD    = 3'd5;
  localparam logic [2:0] S_SH_WR    = 3'd6;
  localparam logic [2:0] S_FINISH   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctrl       = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctrl.latch = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        ctrl.idx_clr = 1'b1;
        if (!stat.is_remove) begin
          ctrl.res_set = 1'b1;
          if (stat.full) begin
            ctrl.res_code = ST_FULL;
          end else begin
            ctrl.res_code  = ST_OK;
            ctrl.wr_insert = 1'b1;
            ctrl.cnt_inc   = 1'b1;
          end
          state_next = S_FINISH;
        end else if (stat.empty) begin
          ctrl.res_set  = 1'b1;
          ctrl.res_code = ST_EMPTY;
          state_next    = S_FINISH;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        ctrl.rd_en = 1'b1;
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (stat.prio_hit) begin
          ctrl.res_set  = 1'b1;
          ctrl.res_take = 1'b1;
          ctrl.res_code = ST_OK;
          state_next    = S_SH_CHK;
        end else if (stat.last) begin
          ctrl.res_set  = 1'b1;
          ctrl.res_code = ST_NOT_FOUND;
          state_next    = S_FINISH;
        end else begin
          ctrl.idx_inc = 1'b1;
          state_next   = S_SCAN_RD;
        end
      end
      S_SH_CHK: begin
        // idx marks the hole; done once nothing sits above it
        if (stat.last) begin
          ctrl.cnt_dec = 1'b1;
          state_next   = S_FINISH;
        end else begin
          state_next = S_SH_RD;
        end
      end
      S_SH_RD: begin
        ctrl.rd_en   = 1'b1;
        ctrl.rd_next = 1'b1;
        state_next   = S_SH_WR;
      end
      S_SH_WR: begin
        ctrl.wr_shift = 1'b1;
        ctrl.idx_inc  = 1'b1;
        state_next    = S_SH_CHK;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          ctrl.load_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/priority_tagged_fifo_queue_unit.sv]
// Top level of the priority tagged FIFO queue unit
// Usage:
//  req channel (req_valid/req_ready/req_word) takes one command word: insert
//  a value with a priority tag at the tail, or remove the oldest entry that
//  carries the given tag. rsp channel (rsp_valid/rsp_ready/rsp_word) returns
//  one word per command: removed value, status code and occupancy.
//  Commands run one at a time through an entry memory with one read port
//  and one write port, so the time per command is set by the memory scan
//  and the one-entry-per-step compaction. An insert or a failure at decode
//  goes straight to the response; a remove scans from the oldest entry until
//  the tag hits or the last entry misses, and a hit then shifts every newer
//  entry down by one. req_ready rises again at the same edge that raises
//  rsp_valid.
//  The response register holds a finished word while the receiver stalls;
//  the next command is still taken, and its result waits until the
//  register frees up.
//  Reset (rst, synchronous) empties the queue and drops any pending
//  response; entry contents are not cleared and need no clearing pass.
`include "priority_tagged_fifo_queue_unit_defines.svh"

module priority_tagged_fifo_queue_unit #(
  parameter int DEPTH = ptfq_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ptfq_pkg::req_t req_word,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ptfq_pkg::rsp_t rsp_word
);
  import ptfq_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  ptfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  ptfq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_word  (req_word),
    .ctrl      (ctrl),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_word  (rsp_word)
  );

  `PTFQ_ASSERT_NOW(a_no_overwrite, ctrl.load_out, stat.out_free)
  `PTFQ_ASSERT_NOW(a_no_grow_full, ctrl.cnt_inc, !stat.full)
  `PTFQ_ASSERT_NOW(a_no_shrink_empty, ctrl.cnt_dec, !stat.empty)
  `PTFQ_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

endmodule

[tb/sv/priority_tagged_fifo_queue_unit_test.sv]
// Self-checking testbench for the priority tagged FIFO queue unit
module priority_tagged_fifo_queue_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ptfq_pkg::*;

  localparam int QDEPTH      = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_WORDS = 380;
  localparam int MAX_PRINTS  = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_word = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_word;

  priority_tagged_fifo_queue_unit #(.DEPTH(QDEPTH)) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_word (req_word),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_word (rsp_word)
  );

  always #4 clk = ~clk;

  // words waiting to be offered, and results predicted for accepted words
  req_t cmd_backlog[$];
  rsp_t predicted_rsp[$];

  // queue contents as the block should hold them, oldest first
  logic signed [VALUE_W-1:0] held_value[$];
  logic [PRIO_W-1:0]         held_prio[$];

  int          send_idle_pct = 0;
  int          rsp_stall_pct = 0;
  bit          hold_trigger  = 1'b0;
  bit          rsp_held      = 1'b0;
  bit          req_taken     = 1'b0;
  int          error_count   = 0;
  int          words_sent    = 0;
  int          words_checked = 0;
  int          occ_peak      = 0;
  int unsigned status_seen[4];
  int unsigned cycle_count   = 0;

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // insert at tail / remove oldest matching tag, compacting the rest
  function automatic rsp_t apply_queue_command(req_t w);
    rsp_t r;
    int   hit;
    hit = -1;
    r.removed_value = '0;
    r.status = ST_OK;
    if (w.cmd == CMD_INSERT) begin
      if (held_value.size() >= QDEPTH) begin
        r.status = ST_FULL;
      end else begin
        held_value.push_back(w.value);
        held_prio.push_back(w.priority_req);
      end
    end else if (held_value.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      foreach (held_prio[i]) begin
        if (hit < 0 && held_prio[i] == w.priority_req) hit = i;
      end
      if (hit < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        r.removed_value = held_value[hit];
        held_value.delete(hit);
        held_prio.delete(hit);
      end
    end
    r.occupancy = OCC_W'(held_value.size());
    if (held_value.size() > occ_peak) occ_peak = held_value.size();
    return r;
  endfunction

  function automatic req_t make_cmd(logic c, logic signed [VALUE_W-1:0] v,
                                    logic [PRIO_W-1:0] p);
    req_t w;
    w.cmd = c;
    w.value = v;
    w.priority_req = p;
    return w;
  endfunction

  // insert bias changes every few dozen words so occupancy sweeps empty..full
  task automatic queue_random_commands(int count);
    int                        insert_pct;
    logic                      c;
    logic signed [VALUE_W-1:0] v;
    logic [PRIO_W-1:0]         p;
    insert_pct = 50;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 85;
          1:       insert_pct = 50;
          default: insert_pct = 20;
        endcase
      end
      c = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
      case ($urandom_range(0, 9))
        0:       v = 32'sh8000_0000;
        1:       v = 32'sh7fff_ffff;
        default: v = $urandom();
      endcase
      // a small tag set keeps removes hitting; the full range mostly misses
      if ($urandom_range(0, 99) < 80) p = PRIO_W'($urandom_range(0, 5));
      else p = PRIO_W'($urandom_range(0, 255));
      cmd_backlog.push_back(make_cmd(c, v, p));
    end
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || req_valid || predicted_rsp.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** priority_tagged_fifo_queue_unit: FAILED **");
      $finish;
    end
  end

  // sender
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req_word  <= cmd_backlog.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    rsp_ready <= !rsp_held && ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  // long receiver hold-off, counted here so the sender keeps pushing
  initial begin
    wait (hold_trigger);
    rsp_held = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rsp_held = 1'b0;
  end

  // monitor and checker
  always @(posedge clk) begin
    rsp_t want;
    req_taken = !rst && req_valid && req_ready;
    if (!rst) begin
      if (req_taken) begin
        predicted_rsp.push_back(apply_queue_command(req_word));
        words_sent++;
      end
      if (rsp_valid && rsp_ready) begin
        if (predicted_rsp.size() == 0) begin
          flag_error($sformatf("unexpected word %h", rsp_word));
        end else begin
          want = predicted_rsp.pop_front();
          words_checked++;
          status_seen[want.status]++;
          if (rsp_word.removed_value !== want.removed_value)
            flag_error($sformatf("word %0d removed_value %h, want %h", words_checked,
                                 rsp_word.removed_value, want.removed_value));
          if (rsp_word.status !== want.status)
            flag_error($sformatf("word %0d status %0d, want %0d", words_checked,
                                 rsp_word.status, want.status));
          if (rsp_word.occupancy !== want.occupancy)
            flag_error($sformatf("word %0d occupancy %0d, want %0d", words_checked,
                                 rsp_word.occupancy, want.occupancy));
        end
      end
    end
  end

  initial begin
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty, only entry, fill with extremes, full, miss, duplicates
    cmd_backlog.push_back(make_cmd(CMD_REMOVE, 32'sh1234_5678, 8'h00));
    cmd_backlog.push_back(make_cmd(CMD_INSERT, 32'sh7fff_ffff, 8'hff));
    cmd_backlog.push_back(make_cmd(CMD_REMOVE, 32'sh0, 8'hff));
    cmd_backlog.push_back(make_cmd(CMD_REMOVE, 32'shffff_ffff, 8'hff));
    for (int i = 0; i < QDEPTH; i++) begin
      case (i)
        0:       cmd_backlog.push_back(make_cmd(CMD_INSERT, 32'sh8000_0000, 8'h00));
        1:       cmd_backlog.push_back(make_cmd(CMD_INSERT, 32'sh7fff_ffff, 8'hff));
        2:       cmd_backlog.push_back(make_cmd(CMD_INSERT, -32'sd1, 8'd34));
        3:       cmd_backlog.push_back(make_cmd(CMD_INSERT, 32'sh0, 8'd51));
        default: cmd_backlog.push_back(make_cmd(CMD_INSERT, 32'sh5555_aaaa ^ i,
                                                PRIO_W'(i * 17)));
      endcase
    end
    cmd_backlog.push_back(make_cmd(CMD_INSERT, 32'sh0bad_f00d, 8'h01));
    cmd_backlog.push_back(make_cmd(CMD_REMOVE, 32'sh0, 8'h01));
    // tag 0xff is held twice: the older one goes first
    cmd_backlog.push_back(make_cmd(CMD_REMOVE, 32'sh0, 8'hff));
    cmd_backlog.push_back(make_cmd(CMD_REMOVE, 32'sh0, 8'hff));
    cmd_backlog.push_back(make_cmd(CMD_REMOVE, 32'sh0, 8'h00));
    queue_random_commands(PHASE_WORDS - 25);
    wait_drained();

    send_idle_pct = 55;
    rsp_stall_pct = 0;
    queue_random_commands(PHASE_WORDS);
    wait_drained();

    send_idle_pct = 0;
    rsp_stall_pct = 55;
    queue_random_commands(PHASE_WORDS);
    wait_drained();

    send_idle_pct = 28;
    rsp_stall_pct = 28;
    queue_random_commands(PHASE_WORDS);
    wait_drained();

    // back-pressure: receiver held off while words keep coming
    send_idle_pct = 0;
    rsp_stall_pct = 10;
    queue_random_commands(PHASE_WORDS);
    hold_trigger = 1'b1;
    wait_drained();

    repeat (3 * QDEPTH + 8) @(posedge clk);
    if (predicted_rsp.size() != 0)
      flag_error($sformatf("%0d results never arrived", predicted_rsp.size()));

    $display("%0d commands sent, %0d results checked, peak occupancy %0d of %0d",
             words_sent, words_checked, occ_peak, QDEPTH);
    $display("status mix: ok %0d, empty %0d, not found %0d, full %0d; %0d mismatches",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_NOT_FOUND],
             status_seen[ST_FULL], error_count);
    if (error_count == 0) begin
      $display("** priority_tagged_fifo_queue_unit: PASSED **");
    end else begin
      $display("** priority_tagged_fifo_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule
